// ----- hw/rtl/cti_pkg.sv -----
// ----------------------------------------------------------------------------
// Calibration table interpolator package
// Shared types, widths and codes for the table, the interpolation unit and
// the top-level sequencer.
// ----------------------------------------------------------------------------
package cti_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam int VAL_W     = 24;              // Q8.16 key and value width
  localparam int DIFF_W    = VAL_W + 1;       // exact difference of two values
  localparam int PROD_W    = 2 * DIFF_W;      // product of two differences
  localparam int SUM_W     = PROD_W + 2;      // base plus signed quotient
  localparam int STEP_W    = $clog2(PROD_W + 1);
  localparam int CFG_W     = 7;
  localparam int OUT_IDX_W = 6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_SINGLE    = 2'd0;
  localparam logic [1:0] ST_INTERP    = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  typedef logic signed [VAL_W-1:0]  value_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    logic                 command;
    logic [OUT_IDX_W-1:0] point_index;
    value_t               key_value;
    value_t               first_value;
    value_t               second_value;
  } request_t;

  typedef struct packed {
    value_t               first_result;
    value_t               second_result;
    logic [OUT_IDX_W-1:0] low_index;
    logic [OUT_IDX_W-1:0] high_index;
    logic [1:0]           status;
  } result_t;

  typedef struct packed {
    value_t key;
    value_t first;
    value_t second;
  } entry_t;

  // Operands of one interpolation: base + round(d * dv / r).
  typedef struct packed {
    diff_t  d;
    diff_t  dv;
    diff_t  r;
    value_t base;
  } lerp_op_t;

  typedef struct packed {
    logic   done;
    logic   sat;
    value_t value;
  } lerp_res_t;

  function automatic diff_t ext_diff(value_t v);
    return {v[VAL_W-1], v};
  endfunction

endpackage

// ----- hw/rtl/calibration_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// Calibration table interpolator
// Loads calibration points and answers queries by piecewise linear
// interpolation over the points in use.
// ----------------------------------------------------------------------------
// A load item writes one point as it is accepted and gives no result; a
// load whose index is at or above TABLE_DEPTH is dropped. A query item scans
// the first points_in_use points (at most TABLE_DEPTH) one table read per
// cycle, stopping at an exact key match, then reads the two bounding points.
// When the bounds differ, each of the two values goes in turn through the
// shared interpolation unit, with its one-bit-per-cycle divider. The block
// takes one item at a time; a finished result sits in the output register,
// and loads and a following query are taken while it waits. points_in_use
// must only be written while idle.
// ----------------------------------------------------------------------------
module calibration_table_interpolator #(
  parameter int TABLE_DEPTH = cti_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      request_valid,
  output logic                      request_stall,
  input  cti_pkg::request_t         request,
  output logic                      result_valid,
  input  logic                      result_stall,
  output cti_pkg::result_t          result,
  input  logic                      config_write,
  input  logic [cti_pkg::CFG_W-1:0] config_data
);
  import cti_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_FETCH_LO = 3'd2;
  localparam logic [2:0] S_FETCH_HI = 3'd3;
  localparam logic [2:0] S_PREP     = 3'd4;
  localparam logic [2:0] S_FIRST    = 3'd5;
  localparam logic [2:0] S_SECOND   = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0]       state;
  logic [CFG_W-1:0] points_in_use;
  value_t           query_key;
  logic [CNT_W-1:0] scan_count;
  logic [CNT_W-1:0] scan_addr;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic             have_lo;
  logic             have_hi;
  diff_t            best_lo;
  diff_t            best_hi;
  entry_t           lo_entry;
  entry_t           hi_entry;
  logic             sat_acc;
  value_t           res_first;
  value_t           res_second;
  logic [1:0]       res_status;

  logic             accept;
  logic             load_we;
  logic [IDX_W+OUT_IDX_W-1:0] load_addr_wide;
  logic [IDX_W+OUT_IDX_W-1:0] lo_wide;
  logic [IDX_W+OUT_IDX_W-1:0] hi_wide;
  entry_t           load_entry;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             issue;
  diff_t            diff;
  logic             diff_pos;
  logic             scan_end;
  entry_t           hi_now;
  logic             single;
  logic             lerp_start;
  lerp_op_t         lerp_op;
  lerp_res_t        lerp_res;
  logic             out_free;

  assign request_stall  = (state != S_IDLE);
  assign accept         = request_valid && !request_stall;
  assign load_we        = accept && (request.command == CMD_LOAD) &&
                          (32'(request.point_index) < TABLE_DEPTH);
  assign load_addr_wide = {IDX_W'(0), request.point_index};
  assign load_entry     = '{key: request.key_value, first: request.first_value,
                            second: request.second_value};

  assign issue    = (state == S_SCAN) && (scan_addr < scan_count);
  assign rd_en    = issue || (state == S_FETCH_LO) || (state == S_FETCH_HI);
  always_comb begin
    unique case (state)
      S_FETCH_LO: rd_addr = lo;
      S_FETCH_HI: rd_addr = hi;
      default:    rd_addr = scan_addr[IDX_W-1:0];
    endcase
  end

  cti_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk          (clk),
    .write_enable (load_we),
    .write_addr   (load_addr_wide[IDX_W-1:0]),
    .write_data   (load_entry),
    .read_enable  (rd_en),
    .read_addr    (rd_addr),
    .read_data    (rd_data)
  );

  assign diff     = ext_diff(rd_data.key) - ext_diff(query_key);
  assign diff_pos = !diff[DIFF_W-1] && (diff != '0);
  assign scan_end = !cmp_valid && !issue;

  // During preparation the upper point is still on the read port.
  assign hi_now = (state == S_PREP) ? rd_data : hi_entry;
  assign single = (lo == hi) || (rd_data.key == lo_entry.key);

  assign lerp_start = ((state == S_PREP) && !single) ||
                      ((state == S_FIRST) && lerp_res.done);
  always_comb begin
    lerp_op.d = ext_diff(query_key) - ext_diff(lo_entry.key);
    lerp_op.r = ext_diff(hi_now.key) - ext_diff(lo_entry.key);
    if (state == S_FIRST) begin
      lerp_op.dv   = ext_diff(hi_now.second) - ext_diff(lo_entry.second);
      lerp_op.base = lo_entry.second;
    end else begin
      lerp_op.dv   = ext_diff(hi_now.first) - ext_diff(lo_entry.first);
      lerp_op.base = lo_entry.first;
    end
  end

  cti_lerp u_lerp (
    .clk   (clk),
    .rst   (rst),
    .start (lerp_start),
    .op    (lerp_op),
    .res   (lerp_res)
  );

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= CFG_W'(1);
    end else if (config_write) begin
      points_in_use <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (request.command == CMD_QUERY)) begin
            query_key  <= request.key_value;
            scan_count <= (32'(points_in_use) > TABLE_DEPTH) ?
                          CNT_W'(TABLE_DEPTH) : CNT_W'(points_in_use);
            scan_addr  <= '0;
            cmp_valid  <= 1'b0;
            lo         <= '0;
            hi         <= '0;
            have_lo    <= 1'b0;
            have_hi    <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          cmp_idx   <= scan_addr[IDX_W-1:0];
          if (issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (cmp_valid && (diff == '0)) begin
            lo        <= cmp_idx;
            hi        <= cmp_idx;
            cmp_valid <= 1'b0;
            state     <= S_FETCH_LO;
          end else begin
            // Strict compares keep the earlier point on a tie.
            if (cmp_valid && diff_pos && (!have_hi || (diff < best_hi))) begin
              hi      <= cmp_idx;
              best_hi <= diff;
              have_hi <= 1'b1;
            end
            if (cmp_valid && !diff_pos && (!have_lo || (diff > best_lo))) begin
              lo      <= cmp_idx;
              best_lo <= diff;
              have_lo <= 1'b1;
            end
            if (scan_end) begin
              state <= S_FETCH_LO;
            end
          end
        end
        S_FETCH_LO: begin
          state <= S_FETCH_HI;
        end
        S_FETCH_HI: begin
          lo_entry <= rd_data;
          state    <= S_PREP;
        end
        S_PREP: begin
          hi_entry <= rd_data;
          if (single) begin
            res_first  <= lo_entry.first;
            res_second <= lo_entry.second;
            res_status <= ST_SINGLE;
            state      <= S_FINISH;
          end else begin
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (lerp_res.done) begin
            res_first <= lerp_res.value;
            sat_acc   <= lerp_res.sat;
            state     <= S_SECOND;
          end
        end
        S_SECOND: begin
          if (lerp_res.done) begin
            res_second <= lerp_res.value;
            res_status <= (sat_acc || lerp_res.sat) ? ST_SATURATED : ST_INTERP;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign lo_wide = {OUT_IDX_W'(0), lo};
  assign hi_wide = {OUT_IDX_W'(0), hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      result.first_result  <= res_first;
      result.second_result <= res_second;
      result.low_index     <= lo_wide[OUT_IDX_W-1:0];
      result.high_index    <= hi_wide[OUT_IDX_W-1:0];
      result.status        <= res_status;
    end
  end

endmodule

// ----- hw/rtl/cti_table.sv -----
// ----------------------------------------------------------------------------
// Calibration point table
// One write port and one read port with registered read data. Entries hold a
// key and two values and are undefined until loaded.
// ----------------------------------------------------------------------------
module cti_table #(
  parameter int TABLE_DEPTH = cti_pkg::TABLE_DEPTH_DEFAULT,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              write_enable,
  input  logic [IDX_W-1:0]  write_addr,
  input  cti_pkg::entry_t   write_data,
  input  logic              read_enable,
  input  logic [IDX_W-1:0]  read_addr,
  output cti_pkg::entry_t   read_data
);
  import cti_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (write_enable) begin
      mem[write_addr] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (read_enable) begin
      read_data <= mem[read_addr];
    end
  end

endmodule

// ----- hw/rtl/cti_lerp.sv -----
// ----------------------------------------------------------------------------
// Interpolation unit
// Computes base + round(d * dv / r) with halves rounded away from zero and
// the sum saturated to 24 bits. One multiply, then a restoring divider that
// retires one quotient bit per cycle. Shared by both result values.
// ----------------------------------------------------------------------------
module cti_lerp (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cti_pkg::lerp_op_t   op,
  output cti_pkg::lerp_res_t  res
);
  import cti_pkg::*;

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_ABS   = 3'd1;
  localparam logic [2:0] L_MUL   = 3'd2;
  localparam logic [2:0] L_BIAS  = 3'd3;
  localparam logic [2:0] L_DIV   = 3'd4;
  localparam logic [2:0] L_FINAL = 3'd5;

  localparam logic [SUM_W-VAL_W:0] HIGH_ONES = '1;

  logic [2:0]        state;
  lerp_op_t          op_q;
  logic [DIFF_W-1:0] mag_d;
  logic [DIFF_W-1:0] mag_dv;
  logic [DIFF_W-1:0] mag_r;
  logic              neg;
  logic [PROD_W-1:0] dvd;
  logic [DIFF_W-1:0] rem;
  logic [STEP_W-1:0] step;
  logic              done;
  logic              sat;
  value_t            value;

  logic [PROD_W-1:0] product;
  logic [DIFF_W:0]   rem_sh;
  logic              fits;
  logic [SUM_W-1:0]  base_ext;
  logic [SUM_W-1:0]  quot_ext;
  logic [SUM_W-1:0]  sum;
  logic              sat_hi;
  logic              sat_lo;

  assign product  = mag_d * mag_dv;
  assign rem_sh   = {rem, dvd[PROD_W-1]};
  assign fits     = rem_sh >= {1'b0, mag_r};
  assign base_ext = {{(SUM_W-VAL_W){op_q.base[VAL_W-1]}}, op_q.base};
  assign quot_ext = {2'b00, dvd};
  assign sum      = neg ? (base_ext - quot_ext) : (base_ext + quot_ext);
  // The sum fits 24 bits only when its top bits all copy the sign bit.
  assign sat_hi   = !sum[SUM_W-1] && (sum[SUM_W-1:VAL_W-1] != '0);
  assign sat_lo   = sum[SUM_W-1] && (sum[SUM_W-1:VAL_W-1] != HIGH_ONES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            op_q  <= op;
            state <= L_ABS;
          end
        end
        L_ABS: begin
          mag_d  <= op_q.d[DIFF_W-1]  ? DIFF_W'(-op_q.d)  : DIFF_W'(op_q.d);
          mag_dv <= op_q.dv[DIFF_W-1] ? DIFF_W'(-op_q.dv) : DIFF_W'(op_q.dv);
          mag_r  <= op_q.r[DIFF_W-1]  ? DIFF_W'(-op_q.r)  : DIFF_W'(op_q.r);
          // A zero product gives a zero quotient, so its sign does not matter.
          neg    <= op_q.d[DIFF_W-1] ^ op_q.dv[DIFF_W-1] ^ op_q.r[DIFF_W-1];
          state  <= L_MUL;
        end
        L_MUL: begin
          dvd   <= product;
          state <= L_BIAS;
        end
        L_BIAS: begin
          dvd   <= dvd + PROD_W'(mag_r >> 1);
          rem   <= '0;
          step  <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          rem  <= fits ? DIFF_W'(rem_sh - {1'b0, mag_r}) : rem_sh[DIFF_W-1:0];
          dvd  <= {dvd[PROD_W-2:0], fits};
          step <= step + 1'b1;
          if (step == STEP_W'(PROD_W - 1)) begin
            state <= L_FINAL;
          end
        end
        L_FINAL: begin
          sat   <= sat_hi || sat_lo;
          value <= sat_hi ? {1'b0, {(VAL_W-1){1'b1}}} :
                   sat_lo ? {1'b1, {(VAL_W-1){1'b0}}} : sum[VAL_W-1:0];
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  assign res = '{done: done, sat: sat, value: value};

endmodule

// ----- hw/rtl/cti_checker.sv -----
// ----------------------------------------------------------------------------
// Calibration table interpolator checker
// Port-level assertions on the item handshakes and result fields, bound to
// the top level.
// ----------------------------------------------------------------------------
module cti_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      request_valid,
  input logic                      request_stall,
  input cti_pkg::request_t         request,
  input logic                      result_valid,
  input logic                      result_stall,
  input cti_pkg::result_t          result,
  input logic                      config_write,
  input logic [cti_pkg::CFG_W-1:0] config_data
);
  import cti_pkg::*;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A result waiting on a stall holds its item.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // A query occupies the engine for the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall && (request.command == CMD_QUERY)
    |=> request_stall)
    else $error("query accepted without engine going busy");

  // A load finishes in its own cycle and leaves the block open.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall && (request.command == CMD_LOAD)
    |=> !request_stall)
    else $error("load left the block busy");

  // A single-point answer uses one point for both bounds.
  a_single_bounds: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_SINGLE)
    |-> result.low_index == result.high_index)
    else $error("single-point result with different bounds");

endmodule

bind calibration_table_interpolator cti_checker u_cti_checker (.*);

// ----- dv/tb_calibration_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// Calibration table interpolator testbench
// Loads calibration points, writes points_in_use between phases and sends
// directed and random queries under random idling and a long output
// hold-off. Each query is predicted by a local scan and rounded linear
// interpolation over a shadow copy of the table, and every result is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_calibration_table_interpolator;
  import cti_pkg::*;

  localparam int     DEPTH         = TABLE_DEPTH_DEFAULT;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     LIMIT_CYCLES  = 2000000;
  localparam int     TOTAL_ITEMS   = 1700;
  localparam int     KEY_STEP      = 262144;
  localparam longint VAL_MAX       = 8388607;
  localparam longint VAL_MIN       = -8388608;

  localparam int PAT_ASCENDING  = 0;
  localparam int PAT_DESCENDING = 1;
  localparam int PAT_SCATTERED  = 2;
  localparam int PAT_CLUSTERED  = 3;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             request_valid = 1'b0;
  logic             request_stall;
  request_t         request       = '0;
  logic             result_valid;
  logic             result_stall  = 1'b0;
  result_t          result;
  logic             config_write  = 1'b0;
  logic [CFG_W-1:0] config_data   = '0;

  // Shadow of the table and of points_in_use (reset value 1).
  value_t           key_mem    [DEPTH];
  value_t           first_mem  [DEPTH];
  value_t           second_mem [DEPTH];
  logic [CFG_W-1:0] scan_count = CFG_W'(1);

  result_t pending_lookups[$];
  result_t oldest;
  bit      steady       = 1'b0;
  int      holdoff_left = 0;
  int      failures     = 0;
  int      items_sent   = 0;
  int      cycle_count  = 0;

  calibration_table_interpolator dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .config_write  (config_write),
    .config_data   (config_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // base + round(d * dv / r), halves away from zero, saturated to 24 bits.
  function automatic value_t lerp_value(value_t base, longint d, longint dv, longint r,
                                        inout bit sat);
    longint          p, q, s;
    longint unsigned ap, ar, aq;
    bit              neg;
    p   = d * dv;
    neg = (p < 0) != (r < 0);
    ap  = (p < 0) ? -p : p;
    ar  = (r < 0) ? -r : r;
    aq  = (ap + ar / 2) / ar;
    q   = neg ? -longint'(aq) : longint'(aq);
    s   = longint'(base) + q;
    if (s > VAL_MAX) begin
      sat = 1'b1;
      return value_t'(VAL_MAX);
    end
    if (s < VAL_MIN) begin
      sat = 1'b1;
      return value_t'(VAL_MIN);
    end
    return value_t'(s);
  endfunction

  function automatic result_t expected_lookup(value_t query);
    result_t res;
    int      n, lo, hi, i;
    bit      have_lo, have_hi, sat;
    longint  diff, best_lo, best_hi, span, d;
    n       = (scan_count > DEPTH) ? DEPTH : int'(scan_count);
    lo      = 0;
    hi      = 0;
    have_lo = 1'b0;
    have_hi = 1'b0;
    best_lo = 0;
    best_hi = 0;
    sat     = 1'b0;
    for (i = 0; i < n; i++) begin
      diff = longint'(key_mem[i]) - longint'(query);
      if (diff == 0) begin
        lo = i;
        hi = i;
        break;
      end
      // Strict comparisons so that ties keep the earlier point.
      if (diff > 0) begin
        if (!have_hi || diff < best_hi) begin
          hi      = i;
          best_hi = diff;
          have_hi = 1'b1;
        end
      end else if (!have_lo || diff > best_lo) begin
        lo      = i;
        best_lo = diff;
        have_lo = 1'b1;
      end
    end
    span           = longint'(key_mem[hi]) - longint'(key_mem[lo]);
    res.low_index  = lo[OUT_IDX_W-1:0];
    res.high_index = hi[OUT_IDX_W-1:0];
    if (lo == hi || span == 0) begin
      res.first_result  = first_mem[lo];
      res.second_result = second_mem[lo];
      res.status        = ST_SINGLE;
    end else begin
      d = longint'(query) - longint'(key_mem[lo]);
      res.first_result  = lerp_value(first_mem[lo], d,
                                     longint'(first_mem[hi]) - longint'(first_mem[lo]),
                                     span, sat);
      res.second_result = lerp_value(second_mem[lo], d,
                                     longint'(second_mem[hi]) - longint'(second_mem[lo]),
                                     span, sat);
      res.status        = sat ? ST_SATURATED : ST_INTERP;
    end
    return res;
  endfunction

  function automatic value_t random_value();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return value_t'(VAL_MAX);
    if (pick == 1) return value_t'(VAL_MIN);
    if (pick < 6) return value_t'($urandom());
    return value_t'(longint'($urandom_range(131072)) - 65536);
  endfunction

  // Query keys mostly land on, between or next to keys in the scanned range.
  function automatic value_t random_query_key();
    int     eff, a, b, pick;
    longint ka, kb, swap;
    eff  = (scan_count == 0) ? 1 : ((scan_count > DEPTH) ? DEPTH : int'(scan_count));
    a    = $urandom_range(eff - 1);
    b    = $urandom_range(eff - 1);
    ka   = longint'(key_mem[a]);
    kb   = longint'(key_mem[b]);
    pick = $urandom_range(19);
    if (ka > kb) begin
      swap = ka;
      ka   = kb;
      kb   = swap;
    end
    if (pick < 6) return key_mem[a];
    if (pick < 12) return value_t'(ka + longint'($urandom_range(32'(kb - ka))));
    if (pick < 15) return value_t'(ka + longint'($urandom_range(8)) - 4);
    if (pick < 17) return $urandom_range(1) ? value_t'(VAL_MAX) : value_t'(VAL_MIN);
    return value_t'($urandom());
  endfunction

  function automatic request_t random_request();
    request_t item;
    item.point_index  = OUT_IDX_W'($urandom_range(DEPTH - 1));
    item.key_value    = random_query_key();
    item.first_value  = random_value();
    item.second_value = random_value();
    item.command      = ($urandom_range(99) < 78) ? CMD_QUERY : CMD_LOAD;
    return item;
  endfunction

  // Every call starts just after a rising edge and returns just after the
  // edge at which the item was accepted.
  task automatic send_item(input request_t item);
    while (!steady && $urandom_range(99) < 17) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request       <= item;
    request_valid <= 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    items_sent++;
    if (item.command == CMD_LOAD) begin
      key_mem[item.point_index]    = item.key_value;
      first_mem[item.point_index]  = item.first_value;
      second_mem[item.point_index] = item.second_value;
    end else begin
      pending_lookups.push_back(expected_lookup(item.key_value));
    end
  endtask

  task automatic load_point(input int slot, input longint key, input longint first,
                            input longint second);
    request_t item;
    item.command      = CMD_LOAD;
    item.point_index  = slot[OUT_IDX_W-1:0];
    item.key_value    = value_t'(key);
    item.first_value  = value_t'(first);
    item.second_value = value_t'(second);
    send_item(item);
  endtask

  task automatic query_key(input longint key);
    request_t item;
    item.command      = CMD_QUERY;
    item.point_index  = OUT_IDX_W'($urandom_range(DEPTH - 1));
    item.key_value    = value_t'(key);
    item.first_value  = random_value();
    item.second_value = random_value();
    send_item(item);
  endtask

  // The block must be idle: no query in flight and no load still settling.
  task automatic set_points_in_use(input int count);
    request_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    config_data  <= CFG_W'(count);
    config_write <= 1'b1;
    @(posedge clk);
    config_write <= 1'b0;
    scan_count = CFG_W'(count);
  endtask

  task automatic fill_table(input int pattern);
    int     fill, slot;
    longint key, step_max;
    fill     = (scan_count == 0) ? 1 : ((scan_count > DEPTH) ? DEPTH : int'(scan_count));
    step_max = longint'(16000000 / fill);
    key      = VAL_MIN + longint'($urandom_range(500000));
    for (slot = 0; slot < fill; slot++) begin
      key = key + longint'($urandom_range(32'(step_max), 1));
      case (pattern)
        PAT_ASCENDING:  load_point(slot, key, random_value(), random_value());
        PAT_DESCENDING: load_point(slot, -key, random_value(), random_value());
        PAT_SCATTERED:  load_point(slot, random_value(), random_value(), random_value());
        default:        load_point(slot, longint'($urandom_range(16)) - 8,
                                   random_value(), random_value());
      endcase
    end
  endtask

  // Writes every slot, so no later scan can reach an unwritten entry.
  task automatic test_table_fill();
    int slot;
    for (slot = 0; slot < DEPTH; slot++)
      load_point(slot, (slot - 32) * KEY_STEP, slot * 65536, -slot * 32768);
  endtask

  // Right after reset only slot 0 is scanned.
  task automatic test_reset_count();
    query_key(12345);
  endtask

  task automatic test_directed_cases();
    set_points_in_use(64);
    query_key(31 * KEY_STEP);
    query_key(-22 * KEY_STEP + KEY_STEP / 2);
    query_key(VAL_MAX);
    query_key(VAL_MIN);
    // A quotient of exactly one half rounds away from zero on both signs.
    load_point(20, -12 * KEY_STEP, 0, 0);
    load_point(21, -11 * KEY_STEP, 1, -1);
    query_key(-12 * KEY_STEP + KEY_STEP / 2);
    // Slots 29 and 30 share a key; the earlier one wins.
    load_point(30, -3 * KEY_STEP, 5, 7);
    query_key(-3 * KEY_STEP);
    query_key(-3 * KEY_STEP + 1000);
    // Extrapolating past the top key with extreme values saturates both.
    load_point(63, 31 * KEY_STEP, VAL_MAX, VAL_MIN);
    load_point(0, VAL_MIN, VAL_MIN, VAL_MAX);
    query_key(VAL_MAX);
    query_key(VAL_MIN + 1);
    set_points_in_use(0);
    query_key(777);
    set_points_in_use(127);
    query_key(5 * KEY_STEP + 3);
    set_points_in_use(2);
    query_key(VAL_MAX);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    set_points_in_use(40);
    holdoff_left = 800;
    repeat (40) send_item(random_request());
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    repeat (200) send_item(random_request());
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    int pick;
    int count;
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(9);
      if (pick == 0) count = 0;
      else if (pick == 1) count = $urandom_range(127, 65);
      else if (pick == 2) count = 1;
      else if (pick == 3) count = 64;
      else count = $urandom_range(63, 2);
      set_points_in_use(count);
      fill_table($urandom_range(PAT_CLUSTERED));
      repeat (80) send_item(random_request());
    end
  endtask

  always @(posedge clk) begin
    if (result_valid && !result_stall) begin
      if (pending_lookups.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: first %0d second %0d low %0d high %0d status %0d",
                   result.first_result, result.second_result, result.low_index,
                   result.high_index, result.status);
      end else begin
        oldest = pending_lookups.pop_front();
        if (result.first_result !== oldest.first_result ||
            result.second_result !== oldest.second_result ||
            result.low_index !== oldest.low_index ||
            result.high_index !== oldest.high_index ||
            result.status !== oldest.status) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected first %0d second %0d low %0d high %0d status %0d, %s",
                     oldest.first_result, oldest.second_result, oldest.low_index,
                     oldest.high_index, oldest.status,
                     $sformatf("got first %0d second %0d low %0d high %0d status %0d",
                               result.first_result, result.second_result,
                               result.low_index, result.high_index, result.status));
        end
      end
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("calibration_table_interpolator verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_table_fill();
    test_reset_count();
    test_directed_cases();
    test_backpressure();
    test_steady_stream();
    test_random_phases();
    request_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("calibration_table_interpolator verification clean");
    end else begin
      $display("calibration_table_interpolator verification failed");
    end
    $finish;
  end

endmodule
